/* rtl/core/cmt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cmt_pkg;

  // Width of the operation code and of the status code.
  localparam int unsigned OP_BITS     = 3;
  localparam int unsigned STATUS_BITS = 2;

  // Request operations.
  typedef enum logic [OP_BITS-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SUB    = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  // Update broadcast to the row of cells.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_COUNT  = 2'd1,
    CELL_APPEND = 2'd2,
    CELL_DELETE = 2'd3
  } cell_op_e;

endpackage : cmt_pkg

`default_nettype wire

/* rtl/core/cmt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One table position: holds a key and its count, flags a hit on the
// current request and takes its neighbour's entry when it or an earlier one is deleted.
module cmt_cell
  import cmt_pkg::*;
#(
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned IDX_BITS   = 4,
  parameter int unsigned TOTAL_BITS = 5,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire logic                  by_index_i,
  input  wire logic [KEY_BITS-1:0]   req_key_i,
  input  wire logic [IDX_BITS-1:0]   req_idx_i,
  input  wire logic [TOTAL_BITS-1:0] total_i,
  input  wire cell_op_e              cmd_i,
  input  wire logic [IDX_BITS-1:0]   pos_i,
  input  wire logic [KEY_BITS-1:0]   wkey_i,
  input  wire logic [COUNT_BITS-1:0] wcount_i,
  input  wire logic [KEY_BITS-1:0]   next_key_i,
  input  wire logic [COUNT_BITS-1:0] next_count_i,
  output logic                       sel_o,
  output logic [KEY_BITS-1:0]        key_o,
  output logic [COUNT_BITS-1:0]      count_o
);

  localparam logic [IDX_BITS-1:0]   MyIdx   = IDX_BITS'(INDEX);
  localparam logic [TOTAL_BITS-1:0] MyTotal = TOTAL_BITS'(INDEX);

  logic                  sel_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  live;
  logic                  sel_d;

  // A position holds a live entry only below the entry total.
  assign live  = (MyTotal < total_i);
  assign sel_d = live & (by_index_i ? (req_idx_i == MyIdx) : (req_key_i == key_q));

  // The hit flag is captured when a request is transferred in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (load_i) begin
      sel_q <= sel_d;
    end
  end

  // Entry update: count write, append, or shift down from the neighbour.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CELL_COUNT: begin
        if (pos_i == MyIdx) begin
          count_q <= wcount_i;
        end
      end
      CELL_APPEND: begin
        if (pos_i == MyIdx) begin
          key_q   <= wkey_i;
          count_q <= wcount_i;
        end
      end
      CELL_DELETE: begin
        if (MyIdx >= pos_i) begin
          key_q   <= next_key_i;
          count_q <= next_count_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign sel_o   = sel_q;
  assign key_o   = key_q;
  assign count_o = count_q;

endmodule : cmt_cell

`default_nettype wire

/* rtl/core/counted_multiset_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                          Direction  Handshake
// request   start_i, op_i, key_i, amount_i, index_i          in         start_i && !busy_o
// result    done_o, found_o, key_out_o, count_out_o,
//           entries_o, status_o                              out        done_o, one cycle
//
// For every request, in the transfer cycle each cell compares its
// stored key (or its position) and registers a hit flag; in the next cycle the
// hit entry is read out of the row, the update is broadcast to the cells and the
// result is registered. The result strobe is high in the following cycle, in
// which a new request may already be transferred. The receiver cannot stall.
// Reset clears the entry total and the control; stored keys and counts are not
// cleared and are only read below the entry total.
module counted_multiset_table
  import cmt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [OP_BITS-1:0]                  op_i,
  input  wire logic [KEY_BITS-1:0]                 key_i,
  input  wire logic [COUNT_BITS-1:0]               amount_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]      index_i,
  output logic                                     done_o,
  output logic                                     found_o,
  output logic [KEY_BITS-1:0]                      key_out_o,
  output logic [COUNT_BITS-1:0]                    count_out_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]         entries_o,
  output logic [STATUS_BITS-1:0]                   status_o
);

  localparam int unsigned IDX_BITS   = $clog2(TABLE_DEPTH);
  localparam int unsigned TOTAL_BITS = $clog2(TABLE_DEPTH + 1);
  localparam logic [TOTAL_BITS-1:0] FullTotal = TOTAL_BITS'(TABLE_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  state_e                  state_q;
  op_e                     op_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [COUNT_BITS-1:0]   amount_q;
  logic [TOTAL_BITS-1:0]   total_q, total_d;
  logic                    done_q;
  logic                    found_q, found_d;
  logic [KEY_BITS-1:0]     key_out_q, key_out_d;
  logic [COUNT_BITS-1:0]   count_out_q, count_out_d;
  status_e                 status_q, status_d;

  logic                    load;
  logic                    by_index;
  cell_op_e                cmd;
  logic [IDX_BITS-1:0]     cmd_pos;
  logic [COUNT_BITS-1:0]   cmd_count;

  logic [TABLE_DEPTH-1:0]  sel;
  logic [KEY_BITS-1:0]     cell_key   [TABLE_DEPTH];
  logic [COUNT_BITS-1:0]   cell_count [TABLE_DEPTH];

  logic                    hit;
  logic [IDX_BITS-1:0]     hit_pos;
  logic [KEY_BITS-1:0]     hit_key;
  logic [COUNT_BITS-1:0]   hit_count;
  logic [COUNT_BITS:0]     sum;

  assign load     = start_i && (state_q == S_IDLE);
  assign by_index = (op_e'(op_i) == OP_READ);

  // The row of cells; on a delete, each cell at or above the deleted position takes its upper neighbour's entry.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]   nkey;
    logic [COUNT_BITS-1:0] ncount;
    if (i + 1 < TABLE_DEPTH) begin : g_mid
      assign nkey   = cell_key[i+1];
      assign ncount = cell_count[i+1];
    end else begin : g_last
      assign nkey   = cell_key[i];
      assign ncount = cell_count[i];
    end
    cmt_cell #(
      .KEY_BITS  (KEY_BITS),
      .COUNT_BITS(COUNT_BITS),
      .IDX_BITS  (IDX_BITS),
      .TOTAL_BITS(TOTAL_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .by_index_i  (by_index),
      .req_key_i   (key_i),
      .req_idx_i   (index_i),
      .total_i     (total_q),
      .cmd_i       (cmd),
      .pos_i       (cmd_pos),
      .wkey_i      (key_q),
      .wcount_i    (cmd_count),
      .next_key_i  (nkey),
      .next_count_i(ncount),
      .sel_o       (sel[i]),
      .key_o       (cell_key[i]),
      .count_o     (cell_count[i])
    );
  end

  // At most one cell is flagged, so its position and entry are gathered by OR.
  always_comb begin
    hit_pos   = '0;
    hit_key   = '0;
    hit_count = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (sel[i]) begin
        hit_pos   = hit_pos | IDX_BITS'(i);
        hit_key   = hit_key | cell_key[i];
        hit_count = hit_count | cell_count[i];
      end
    end
  end

  assign hit = |sel;
  assign sum = {1'b0, hit_count} + {1'b0, amount_q};

  // Work out the result and the update of the row for the request held.
  always_comb begin
    cmd         = CELL_HOLD;
    cmd_pos     = hit_pos;
    cmd_count   = '0;
    total_d     = total_q;
    found_d     = 1'b0;
    key_out_d   = key_q;
    count_out_d = '0;
    status_d    = ST_OK;
    case (op_q)
      OP_ADD: begin
        if (hit) begin
          cmd         = CELL_COUNT;
          cmd_count   = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
          found_d     = 1'b1;
          count_out_d = cmd_count;
        end else if (total_q < FullTotal) begin
          cmd         = CELL_APPEND;
          cmd_pos     = total_q[IDX_BITS-1:0];
          cmd_count   = amount_q;
          total_d     = total_q + 1'b1;
          found_d     = 1'b1;
          count_out_d = amount_q;
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          status_d = ST_NOT_FOUND;
        end else if (hit_count > COUNT_BITS'(1)) begin
          cmd         = CELL_COUNT;
          cmd_count   = hit_count - 1'b1;
          found_d     = 1'b1;
          count_out_d = cmd_count;
        end else begin
          cmd     = CELL_DELETE;
          total_d = total_q - 1'b1;
          found_d = 1'b1;
        end
      end
      OP_SUB: begin
        if (!hit) begin
          status_d = ST_NOT_FOUND;
        end else begin
          cmd     = CELL_COUNT;
          found_d = 1'b1;
          if (hit_count >= amount_q) begin
            cmd_count = hit_count - amount_q;
          end else begin
            status_d = ST_UNDERFLOW;
          end
          count_out_d = cmd_count;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          found_d     = 1'b1;
          count_out_d = hit_count;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_READ: begin
        if (hit) begin
          found_d     = 1'b1;
          key_out_d   = hit_key;
          count_out_d = hit_count;
        end else begin
          key_out_d = '0;
          status_d  = ST_NOT_FOUND;
        end
      end
      default: begin
        key_out_d = '0;
      end
    endcase
    if (state_q != S_APPLY) begin
      cmd = CELL_HOLD;
    end
  end

  // Sequencer, request registers and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ADD;
      key_q       <= '0;
      amount_q    <= '0;
      total_q     <= '0;
      done_q      <= 1'b0;
      found_q     <= 1'b0;
      key_out_q   <= '0;
      count_out_q <= '0;
      status_q    <= ST_OK;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q     <= op_e'(op_i);
            key_q    <= key_i;
            amount_q <= amount_i;
            state_q  <= S_APPLY;
          end
        end
        S_APPLY: begin
          total_q     <= total_d;
          done_q      <= 1'b1;
          found_q     <= found_d;
          key_out_q   <= key_out_d;
          count_out_q <= count_out_d;
          status_q    <= status_d;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q == S_APPLY);
  assign done_o      = done_q;
  assign found_o     = found_q;
  assign key_out_o   = key_out_q;
  assign count_out_o = count_out_q;
  assign entries_o   = total_q;
  assign status_o    = status_q;

endmodule : counted_multiset_table

`default_nettype wire

/* rtl/core/cmt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on request sequencing and result consistency.
module cmt_checker
  import cmt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start_i,
  input wire logic                              busy_o,
  input wire logic                              done_o,
  input wire logic                              found_o,
  input wire logic [COUNT_BITS-1:0]             count_out_o,
  input wire logic [$clog2(TABLE_DEPTH+1)-1:0]  entries_o,
  input wire logic [STATUS_BITS-1:0]            status_o
);

  localparam int unsigned TOTAL_BITS = $clog2(TABLE_DEPTH + 1);
  localparam logic [TOTAL_BITS-1:0] FullTotal = TOTAL_BITS'(TABLE_DEPTH);

  // A transferred request makes the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after a request transfer");

  // Every busy cycle is followed by exactly one result strobe.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (done_o && !busy_o))
    else $error("no result after a busy cycle");

  // A full status only appears with every position in use.
  a_full_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (!found_o && (entries_o == FullTotal)))
    else $error("table full reported with free positions");

  // A miss reports no count.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_NOT_FOUND)) |-> (!found_o && (count_out_o == '0)))
    else $error("miss reported with a count");

  // The entry total never exceeds the table depth.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_o <= FullTotal)
    else $error("entry total beyond table depth");

endmodule : cmt_checker

bind counted_multiset_table cmt_checker #(
  .TABLE_DEPTH(TABLE_DEPTH),
  .COUNT_BITS (COUNT_BITS)
) u_cmt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .found_o    (found_o),
  .count_out_o(count_out_o),
  .entries_o  (entries_o),
  .status_o   (status_o)
);

`default_nettype wire
